@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ src/gpev_pkg.sv @@
// Types, constants and tables of the gamepad event converter.
package gpev_pkg;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DZ   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RLO  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RHI  = 3'd4;

	localparam logic [1:0] MODE_XIN = 2'd2;

	localparam int AXIS_UNITY   = 10000;
	localparam int HAT_STEP     = 4500;
	localparam int TRIG_FULL    = 255;
	localparam int BTN_ON       = 128;
	localparam int LOG_HIGH_MAG = 32767;
	localparam int LOG_LOW_MAG  = 32768;

	localparam int QUEUE_DEPTH = 4;
	localparam int MAG_W = 17;
	localparam int NUM_W = 2 * MAG_W + 1;
	localparam int DEN_W = MAG_W;
	localparam int VAL_W = 20;
	localparam int SLOTS = 18;

	typedef enum logic [1:0] {EV_PLAIN, EV_AXIS, EV_TRIG_L, EV_TRIG_R} ev_kind_t;

	typedef struct packed {
		ev_kind_t kind;
		logic [4:0] index;
		logic signed [16:0] raw;
		logic [31:0] seq;
		logic last;
	} event_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [13:0] deadzone;
		logic [13:0] saturation;
		logic signed [16:0] range_low;
		logic signed [16:0] range_high;
	} cfg_t;

	function automatic logic [3:0] std_btn_slot(input logic [3:0] b);
		logic [3:0] s;
		unique case (b)
			4'd0: s = 4'd1;
			4'd1: s = 4'd2;
			4'd2: s = 4'd0;
			4'd3: s = 4'd3;
			4'd4: s = 4'd4;
			4'd5: s = 4'd5;
			4'd6: s = 4'd8;
			4'd7: s = 4'd9;
			4'd8: s = 4'd10;
			4'd9: s = 4'd11;
			4'd10: s = 4'd6;
			4'd11: s = 4'd7;
			default: s = 4'd0;
		endcase
		return s;
	endfunction
endpackage

@@ src/gpev_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module gpev_div #(
	parameter int NW = gpev_pkg::NUM_W,
	parameter int DW = gpev_pkg::DEN_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);
	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    num_q;
	logic [DW-1:0]    den_q;
	logic [DW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic             fits;

	assign trial = {rem_q, num_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NW-2:0], fits};
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;
endmodule

@@ src/gpev_fifo.sv @@
// Short word queue between the report front end and the scaling back end.
module gpev_fifo #(
	parameter int DEPTH = gpev_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gpev_pkg::event_t  wdata,
	input  logic              pop,
	output gpev_pkg::event_t  rdata,
	output logic              full,
	output logic              empty
);
	import gpev_pkg::*;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	event_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = cnt_q == CNT_W'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end
endmodule

@@ src/gpev_front.sv @@
// Report front end: change detection, state update and event listing.
module gpev_front (
	input  logic                clk,
	input  logic                arst_n,
	input  gpev_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  left_x,
	input  logic signed [15:0]  left_y,
	input  logic signed [15:0]  right_x,
	input  logic signed [15:0]  right_y,
	input  logic [7:0]          left_trigger,
	input  logic [7:0]          right_trigger,
	input  logic [15:0]         button_bits,
	input  logic signed [3:0]   hat_dir,
	output gpev_pkg::event_t    ev,
	output logic                ev_push,
	input  logic                ev_full
);
	import gpev_pkg::*;
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic              state_q;
	logic [15:0]       prev_stick_q [4];
	logic [7:0]        prev_lt_q, prev_rt_q;
	logic [15:0]       prev_btn_q;
	logic [3:0]        prev_hat_q;
	logic [31:0]       count_q;

	logic [SLOTS-1:0]  mask_q;
	logic [15:0]       stick_q [4];
	logic              trig_l_q;
	logic [7:0]        trig_raw_q;
	logic [15:0]       btn_q;
	logic [3:0]        hat_q;
	logic [31:0]       seq_q;
	logic              std_q;

	logic [15:0]       stick_in [4];
	logic              accept, std, xin, act, trig_chg, btn_chg;
	logic [3:0]        stick_chg;
	logic [SLOTS-1:0]  mask_new;
	logic [4:0]        slot;
	logic [3:0]        bslot;

	assign stick_in[0] = left_x;
	assign stick_in[1] = left_y;
	assign stick_in[2] = right_x;
	assign stick_in[3] = right_y;

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != ST_IDLE;
	assign std      = cfg.mode[0];
	assign xin      = !std && cfg.mode[1];
	assign act      = std || xin;
	assign trig_chg = (left_trigger != prev_lt_q) || (right_trigger != prev_rt_q);
	assign btn_chg  = button_bits != prev_btn_q;

	always_comb begin
		for (int i = 0; i < 4; i++) stick_chg[i] = stick_in[i] != prev_stick_q[i];
		mask_new[3:0]  = act ? stick_chg : 4'b0;
		mask_new[4]    = xin && trig_chg;
		mask_new[16:5] = (act && btn_chg) ? (std ? 12'hFFF : 12'h3FF) : 12'h000;
		mask_new[17]   = act && (hat_dir != prev_hat_q);
	end

	always_comb begin
		slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (mask_q[i]) slot = 5'(i);
		end
	end

	assign bslot = 4'(slot - 5'd5);

	always_comb begin
		ev.seq  = seq_q;
		ev.last = (mask_q & (mask_q - 1'b1)) == '0;
		ev.kind = EV_PLAIN;
		if (slot < 5'd4) begin
			ev.kind  = EV_AXIS;
			ev.index = (std_q || slot < 5'd2) ? slot : slot + 5'd1;
			ev.raw   = 17'(signed'(stick_q[slot[1:0]]));
		end else if (slot == 5'd4) begin
			ev.kind  = trig_l_q ? EV_TRIG_L : EV_TRIG_R;
			ev.index = 5'd2;
			ev.raw   = {9'b0, trig_raw_q};
		end else if (slot < 5'd17) begin
			ev.index = std_q ? 5'd4 + 5'(std_btn_slot(bslot)) : 5'd5 + 5'(bslot);
			ev.raw   = btn_q[bslot] ? 17'(BTN_ON) : 17'd0;
		end else begin
			ev.index = std_q ? 5'd16 : 5'd15;
			ev.raw   = hat_q[3] ? -17'sd1 : 17'(hat_q[2:0]) * 17'(HAT_STEP);
		end
	end

	assign ev_push = (state_q == ST_WALK) && (mask_q != '0) && !ev_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mask_q     <= '0;
			for (int i = 0; i < 4; i++) prev_stick_q[i] <= '0;
			prev_lt_q  <= '0;
			prev_rt_q  <= '0;
			prev_btn_q <= '0;
			prev_hat_q <= '0;
			count_q    <= '0;
		end else if (accept) begin
			state_q <= ST_WALK;
			mask_q  <= mask_new;
			count_q <= count_q + 1'b1;
			for (int i = 0; i < 4; i++) begin
				if (mask_new[i]) prev_stick_q[i] <= stick_in[i];
			end
			if (mask_new[4]) begin
				prev_lt_q <= left_trigger;
				prev_rt_q <= right_trigger;
			end
			if (act) begin
				prev_btn_q <= button_bits;
				prev_hat_q <= hat_dir;
			end
		end else if (state_q == ST_WALK) begin
			if (mask_q == '0) state_q <= ST_IDLE;
			else if (ev_push) mask_q <= mask_q & (mask_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 4; i++) stick_q[i] <= stick_in[i];
			trig_l_q   <= left_trigger != prev_lt_q;
			trig_raw_q <= (left_trigger != prev_lt_q) ? left_trigger : right_trigger;
			btn_q      <= button_bits;
			hat_q      <= hat_dir;
			seq_q      <= count_q;
			std_q      <= std;
		end
	end
endmodule

@@ src/gpev_back.sv @@
// Back end: axis scaling with deadzone and saturation, output register.
module gpev_back (
	input  logic                clk,
	input  logic                arst_n,
	input  gpev_pkg::cfg_t      cfg,
	input  gpev_pkg::event_t    ev,
	input  logic                ev_empty,
	output logic                ev_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [4:0]          object_index,
	output logic signed [16:0]  event_value,
	output logic [31:0]         sequence_res,
	output logic                last_event
);
	import gpev_pkg::*;
	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_MUL  = 3'd1;
	localparam logic [2:0] B_DIV  = 3'd2;
	localparam logic [2:0] B_WAIT = 3'd3;
	localparam logic [2:0] B_CMP  = 3'd4;
	localparam logic [2:0] B_EMIT = 3'd5;
	localparam logic [1:0] PH_TRIG = 2'd0;
	localparam logic [1:0] PH_DZ   = 2'd1;
	localparam logic [1:0] PH_SAT  = 2'd2;
	localparam logic [1:0] PH_FIN  = 2'd3;

	logic [2:0]              state_q;
	logic [1:0]              phase_q;
	event_t                  ev_q;
	logic signed [VAL_W-1:0] v_q, dz_r_q, sat_r_q;
	logic [MAG_W-1:0]        mag_a_q, mag_b_q, den_q;
	logic                    neg_q;
	logic [2*MAG_W-1:0]      prod_q;
	logic signed [16:0]      res_q;
	logic                    out_valid_q;

	logic                    div_start, div_done;
	logic [NUM_W-1:0]        div_quot;
	logic signed [VAL_W-1:0] div_r, ev_v, trig_v, nv;
	logic signed [VAL_W-1:0] rsum, pctr, lo, hi, pmin, pmax, span;
	logic                    neg_side, out_free;

	gpev_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({1'b0, prod_q} + NUM_W'(den_q >> 1)),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign div_start = state_q == B_DIV;
	assign div_r  = neg_q ? -$signed({1'b0, div_quot[VAL_W-2:0]})
	                      :  $signed({1'b0, div_quot[VAL_W-2:0]});
	assign ev_v   = VAL_W'(ev.raw) + VAL_W'(1);
	assign trig_v = div_r + VAL_W'(1);
	assign nv     = (phase_q == PH_TRIG) ? trig_v : ev_v;

	assign rsum = VAL_W'(cfg.range_low) + VAL_W'(cfg.range_high);
	always_comb begin
		if (cfg.range_low == '0) pctr = VAL_W'(cfg.range_high) >>> 1;
		else if (!rsum[0]) pctr = rsum >>> 1;
		else if (rsum > 0) pctr = (rsum + VAL_W'(1)) >>> 1;
		else pctr = (rsum - VAL_W'(1)) >>> 1;
	end

	assign neg_side = v_q <= 0;
	assign lo   = neg_side ? sat_r_q : dz_r_q;
	assign hi   = neg_side ? dz_r_q : sat_r_q;
	assign pmin = neg_side ? VAL_W'(cfg.range_low) : pctr;
	assign pmax = neg_side ? pctr : VAL_W'(cfg.range_high);
	assign span = pmax - pmin;

	assign out_free = !out_valid_q || !out_stall;
	assign ev_pop   = (state_q == B_IDLE) && !ev_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != B_EMIT) out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (ev_pop) state_q <= (ev.kind == EV_PLAIN) ? B_EMIT : B_MUL;
				end
				B_MUL: state_q <= B_DIV;
				B_DIV: state_q <= B_WAIT;
				B_WAIT: begin
					if (div_done) state_q <= (phase_q == PH_SAT) ? B_CMP
					                       : (phase_q == PH_FIN) ? B_EMIT : B_MUL;
				end
				B_CMP: state_q <= (v_q <= lo || v_q >= hi) ? B_EMIT : B_MUL;
				B_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				ev_q  <= ev;
				res_q <= ev.raw;
				if (ev.kind == EV_TRIG_L || ev.kind == EV_TRIG_R) begin
					phase_q <= PH_TRIG;
					mag_a_q <= MAG_W'(ev.raw[7:0]);
					mag_b_q <= (ev.kind == EV_TRIG_L) ? MAG_W'(LOG_LOW_MAG)
					                                  : MAG_W'(LOG_HIGH_MAG);
					neg_q   <= ev.kind == EV_TRIG_L;
					den_q   <= MAG_W'(TRIG_FULL);
				end else begin
					phase_q <= PH_DZ;
					v_q     <= ev_v;
					mag_a_q <= (ev_v <= 0) ? MAG_W'(LOG_HIGH_MAG) : MAG_W'(LOG_LOW_MAG);
					mag_b_q <= MAG_W'(cfg.deadzone);
					neg_q   <= ev_v <= 0;
					den_q   <= MAG_W'(AXIS_UNITY);
				end
			end
			B_MUL: prod_q <= mag_a_q * mag_b_q;
			B_WAIT: begin
				if (div_done) begin
					unique case (phase_q)
						PH_TRIG: begin
							phase_q <= PH_DZ;
							v_q     <= nv;
							mag_a_q <= (nv <= 0) ? MAG_W'(LOG_HIGH_MAG)
							                     : MAG_W'(LOG_LOW_MAG);
							mag_b_q <= MAG_W'(cfg.deadzone);
							neg_q   <= nv <= 0;
							den_q   <= MAG_W'(AXIS_UNITY);
						end
						PH_DZ: begin
							phase_q <= PH_SAT;
							dz_r_q  <= div_r;
							mag_b_q <= MAG_W'(cfg.saturation);
						end
						PH_SAT: sat_r_q <= div_r;
						PH_FIN: res_q <= 17'(pmin + div_r);
						default: ;
					endcase
				end
			end
			B_CMP: begin
				if (v_q <= lo) res_q <= 17'(pmin);
				else if (v_q >= hi) res_q <= 17'(pmax);
				phase_q <= PH_FIN;
				mag_a_q <= MAG_W'(v_q - lo);
				mag_b_q <= MAG_W'(span < 0 ? -span : span);
				neg_q   <= span < 0;
				den_q   <= MAG_W'(hi - lo);
			end
			B_EMIT: begin
				if (out_free) begin
					object_index <= ev_q.index;
					event_value  <= res_q;
					sequence_res <= ev_q.seq;
					last_event   <= ev_q.last;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

@@ src/gamepad_report_to_axis_events.sv @@
// Top level: gamepad report to axis, button and hat event words.
//  channel  handshake                 payload
//  cfg      cfg_valid / cfg_ready     cfg_index, cfg_data
//  in       in_valid / in_stall       sticks, triggers, button_bits, hat_dir
//  out      out_valid / out_stall     object_index, event_value, sequence_res, last_event
// From the accept the front end stalls new reports while it lists the event words into a
// queue of QUEUE_DEPTH words, one word per cycle while the queue is not full, then idles.
// Button and hat words bypass the back end divider; a stick word takes multiply-divide
// passes on the shared serial divider for the deadzone and saturation bounds and, unless
// clamped, the scaled value, a trigger word one pass more. Reset clears all kept controls
// and the report count; no clearing pass. Either side may stall at any time without loss.
`include "assert_macros.svh"
module gamepad_report_to_axis_events #(
	parameter int QUEUE_DEPTH = gpev_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gpev_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gpev_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [15:0]                left_x,
	input  logic signed [15:0]                left_y,
	input  logic signed [15:0]                right_x,
	input  logic signed [15:0]                right_y,
	input  logic [7:0]                        left_trigger,
	input  logic [7:0]                        right_trigger,
	input  logic [15:0]                       button_bits,
	input  logic signed [3:0]                 hat_dir,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [4:0]                        object_index,
	output logic signed [16:0]                event_value,
	output logic [31:0]                       sequence_res,
	output logic                              last_event
);
	import gpev_pkg::*;

	cfg_t   cfg_q;
	event_t ev_in, ev_out;
	logic   ev_push, ev_pop, ev_full, ev_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= MODE_XIN;
			cfg_q.deadzone   <= '0;
			cfg_q.saturation <= 14'(AXIS_UNITY);
			cfg_q.range_low  <= '0;
			cfg_q.range_high <= 17'sd65535;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE: cfg_q.mode       <= cfg_data[1:0];
				CFG_DZ:   cfg_q.deadzone   <= cfg_data[13:0];
				CFG_SAT:  cfg_q.saturation <= cfg_data[13:0];
				CFG_RLO:  cfg_q.range_low  <= cfg_data;
				CFG_RHI:  cfg_q.range_high <= cfg_data;
				default: ;
			endcase
		end
	end

	gpev_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.left_x        (left_x),
		.left_y        (left_y),
		.right_x       (right_x),
		.right_y       (right_y),
		.left_trigger  (left_trigger),
		.right_trigger (right_trigger),
		.button_bits   (button_bits),
		.hat_dir       (hat_dir),
		.ev            (ev_in),
		.ev_push       (ev_push),
		.ev_full       (ev_full)
	);

	gpev_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ev_push),
		.wdata  (ev_in),
		.pop    (ev_pop),
		.rdata  (ev_out),
		.full   (ev_full),
		.empty  (ev_empty)
	);

	gpev_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.ev           (ev_out),
		.ev_empty     (ev_empty),
		.ev_pop       (ev_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.object_index (object_index),
		.event_value  (event_value),
		.sequence_res (sequence_res),
		.last_event   (last_event)
	);

	`ASSERT_NEVER(a_push_full, clk, arst_n, ev_push && ev_full, "push into full queue")
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, ev_pop && ev_empty, "pop from empty queue")
	`ASSERT_IMPLIES(a_busy_after_accept, clk, arst_n, (in_valid && !in_stall) |=> in_stall, "front not busy after report")
endmodule

@@ verif/gamepad_report_to_axis_events_checker.sv @@
// Checker: watches the config, report and event channels, predicts event words and compares.
`timescale 1ns / 1ps
module gamepad_report_to_axis_events_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [15:0] left_x,
	input  logic signed [15:0] left_y,
	input  logic signed [15:0] right_x,
	input  logic signed [15:0] right_y,
	input  logic [7:0]         left_trigger,
	input  logic [7:0]         right_trigger,
	input  logic [15:0]        button_bits,
	input  logic signed [3:0]  hat_dir,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [4:0]         object_index,
	input  logic signed [16:0] event_value,
	input  logic [31:0]        sequence_res,
	input  logic               last_event,
	output int                 fail_count,
	output int                 pending,
	output int                 events_seen
);
	import gpev_pkg::*;

	typedef struct {
		logic [4:0]  index;
		logic [16:0] value;
		logic [31:0] seq;
		logic        last;
	} event_word_t;

	event_word_t expected_events[$];
	event_word_t report_events[$];

	logic [1:0]   mode;
	longint       dz, sat, rlo, rhi;
	logic [15:0]  kept_sticks [4];
	logic [7:0]   kept_trig [2];
	logic [15:0]  kept_buttons;
	logic [3:0]   kept_hat;
	logic [31:0]  report_count;

	localparam logic [4:0] STD_AXIS [4] = '{5'd0, 5'd1, 5'd2, 5'd3};
	localparam logic [4:0] XIN_AXIS [4] = '{5'd0, 5'd1, 5'd3, 5'd4};
	localparam int STD_BTN [12] = '{1, 2, 0, 3, 4, 5, 8, 9, 10, 11, 6, 7};

	function automatic longint round_muldiv(longint a, longint b, longint c);
		longint p, half, r;
		if (c == 0)
			return -1;
		if (c < 0) begin
			a = -a;
			c = -c;
		end
		p = a * b;
		half = c / 2;
		if ((a < 0) != (b < 0))
			r = (p - half) / c;
		else
			r = (p + half) / c;
		if (r > 64'sd2147483647 || r < -64'sd2147483647)
			return -1;
		return r;
	endfunction

	function automatic longint scaled_axis(longint v);
		longint pmin, pmax, pctr, lo, hi, s;
		pmin = rlo;
		pmax = rhi;
		if (pmin == 0)
			pctr = pmax >= 0 ? pmax / 2 : -((-pmax + 1) / 2);
		else begin
			s = pmin + pmax;
			if ((s & 1) == 0)
				pctr = s / 2;
			else
				pctr = s > 0 ? (s + 1) / 2 : (s - 1) / 2;
		end
		v = v + 1;
		if (v <= 0) begin
			hi = round_muldiv(-32767, dz, AXIS_UNITY);
			lo = round_muldiv(-32767, sat, AXIS_UNITY);
			pmax = pctr;
		end else begin
			lo = round_muldiv(32768, dz, AXIS_UNITY);
			hi = round_muldiv(32768, sat, AXIS_UNITY);
			pmin = pctr;
		end
		if (v <= lo)
			return pmin;
		if (v >= hi)
			return pmax;
		return pmin + round_muldiv(v - lo, pmax - pmin, hi - lo);
	endfunction

	task automatic add_event(logic [4:0] idx, longint val);
		event_word_t w;
		w.index = idx;
		w.value = val[16:0];
		w.seq = report_count;
		w.last = 1'b0;
		report_events.push_back(w);
	endtask

	task automatic predict_report();
		logic [15:0] sticks [4];
		logic        std_lay, xin_lay;
		logic [3:0]  hat_raw;
		longint      raw;
		int          n;
		sticks[0] = left_x;
		sticks[1] = left_y;
		sticks[2] = right_x;
		sticks[3] = right_y;
		hat_raw = hat_dir;
		std_lay = mode[0];
		xin_lay = !mode[0] && mode[1];
		report_events.delete();
		if (std_lay || xin_lay) begin
			for (int i = 0; i < 4; i++)
				if (sticks[i] != kept_sticks[i]) begin
					kept_sticks[i] = sticks[i];
					add_event(std_lay ? STD_AXIS[i] : XIN_AXIS[i],
						scaled_axis(longint'($signed(sticks[i]))));
				end
			if (xin_lay && (left_trigger != kept_trig[0] || right_trigger != kept_trig[1])) begin
				if (left_trigger != kept_trig[0])
					raw = round_muldiv(longint'(left_trigger), -32768, TRIG_FULL);
				else
					raw = round_muldiv(longint'(right_trigger), 32767, TRIG_FULL);
				add_event(5'd2, scaled_axis(raw));
				kept_trig[0] = left_trigger;
				kept_trig[1] = right_trigger;
			end
			if (button_bits != kept_buttons) begin
				kept_buttons = button_bits;
				n = std_lay ? 12 : 10;
				for (int i = 0; i < n; i++)
					add_event(std_lay ? 5'(4 + STD_BTN[i]) : 5'(5 + i),
						button_bits[i] ? BTN_ON : 0);
			end
			if (hat_raw != kept_hat) begin
				kept_hat = hat_raw;
				add_event(std_lay ? 5'd16 : 5'd15,
					hat_dir >= 0 ? longint'(hat_dir) * HAT_STEP : -1);
			end
		end
		if (report_events.size() > 0)
			report_events[report_events.size() - 1].last = 1'b1;
		foreach (report_events[k])
			expected_events.push_back(report_events[k]);
		report_count = report_count + 1;
	endtask

	task automatic compare_event();
		event_word_t w;
		events_seen++;
		if (expected_events.size() == 0) begin
			$error("unexpected event word: index %0d value %0d", object_index, event_value);
			fail_count++;
			return;
		end
		w = expected_events.pop_front();
		if (object_index != w.index) begin
			$error("object_index: expected %0d actual %0d", w.index, object_index);
			fail_count++;
		end
		if (event_value != w.value) begin
			$error("event_value: expected %0d actual %0d", $signed(w.value), event_value);
			fail_count++;
		end
		if (sequence_res != w.seq) begin
			$error("sequence_res: expected %0d actual %0d", w.seq, sequence_res);
			fail_count++;
		end
		if (last_event != w.last) begin
			$error("last_event: expected %0d actual %0d", w.last, last_event);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = MODE_XIN;
			dz = 0;
			sat = AXIS_UNITY;
			rlo = 0;
			rhi = 65535;
			foreach (kept_sticks[i])
				kept_sticks[i] = '0;
			kept_trig[0] = '0;
			kept_trig[1] = '0;
			kept_buttons = '0;
			kept_hat = '0;
			report_count = '0;
			expected_events.delete();
			fail_count = 0;
			events_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MODE: mode = cfg_data[1:0];
					CFG_DZ:   dz = longint'(cfg_data[13:0]);
					CFG_SAT:  sat = longint'(cfg_data[13:0]);
					CFG_RLO:  rlo = longint'($signed(cfg_data));
					CFG_RHI:  rhi = longint'($signed(cfg_data));
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_report();
			if (out_valid && !out_stall)
				compare_event();
		end
		pending = expected_events.size();
	end
endmodule

@@ verif/gamepad_report_to_axis_events_tb.sv @@
// Testbench top: clock, reset, config phases, report stimulus and verdict.
`timescale 1ns / 1ps
module gamepad_report_to_axis_events_tb;
	import gpev_pkg::*;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int DRAIN_CYCLES = 400;
	localparam int PHASE_ITEMS = 53;

	typedef struct {
		logic [15:0] lx, ly, rx, ry;
		logic [7:0]  lt, rt;
		logic [15:0] btn;
		logic [3:0]  hat;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] left_x = '0, left_y = '0, right_x = '0, right_y = '0;
	logic [7:0] left_trigger = '0, right_trigger = '0;
	logic [15:0] button_bits = '0;
	logic signed [3:0] hat_dir = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [4:0] object_index;
	logic signed [16:0] event_value;
	logic [31:0] sequence_res;
	logic last_event;

	int fail_count, pending, events_seen;
	int reports_sent = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	logic word_taken = 1'b0;
	logic no_idle = 1'b0;
	report_t last_report = '{default: '0};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	gamepad_report_to_axis_events u_top (.*);

	gamepad_report_to_axis_events_checker u_checker (.*);

	always @(posedge clk)
		word_taken <= out_valid && !out_stall;

	always @(negedge clk) begin
		if (word_taken && !no_idle)
			stall_left = $urandom_range(0, 7);
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [1:0] m, int dzv, int satv, int lo, int hi);
		@(negedge clk);
		in_valid <= 1'b0;
		settle();
		write_reg(CFG_MODE, 17'(m));
		write_reg(CFG_DZ, 17'(dzv));
		write_reg(CFG_SAT, 17'(satv));
		write_reg(CFG_RLO, 17'(lo));
		write_reg(CFG_RHI, 17'(hi));
	endtask

	task automatic send_report(report_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		left_x <= r.lx;
		left_y <= r.ly;
		right_x <= r.rx;
		right_y <= r.ry;
		left_trigger <= r.lt;
		right_trigger <= r.rt;
		button_bits <= r.btn;
		hat_dir <= r.hat;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		last_report = r;
		reports_sent++;
	endtask

	function automatic logic [15:0] pick_stick(logic [15:0] old);
		case ($urandom_range(0, 7))
			0, 1, 2: return old;
			3: return 16'h8000;
			4: return 16'h7FFF;
			5: return 16'(old + $urandom_range(0, 6) - 3);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_trig(logic [7:0] old);
		case ($urandom_range(0, 5))
			0, 1, 2: return old;
			3: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic random_reports(int n);
		report_t r;
		repeat (n) begin
			r = last_report;
			r.lx = pick_stick(r.lx);
			r.ly = pick_stick(r.ly);
			r.rx = pick_stick(r.rx);
			r.ry = pick_stick(r.ry);
			r.lt = pick_trig(r.lt);
			r.rt = pick_trig(r.rt);
			if ($urandom_range(0, 2) == 0)
				r.btn = 16'($urandom);
			if ($urandom_range(0, 2) == 0)
				r.hat = 4'($urandom);
			send_report(r);
		end
	endtask

	task automatic directed_reports();
		report_t r;
		r = '{default: '0};
		send_report(r);
		r.lx = 16'h8000; r.ly = 16'h7FFF; r.rx = 16'hFFFF; r.ry = 16'h0001;
		send_report(r);
		r.lx = 16'h7FFF; r.ly = 16'h8000; r.rx = 16'h0000; r.ry = 16'hFFFE;
		send_report(r);
		r.lt = 8'hFF;
		send_report(r);
		r.rt = 8'hFF;
		send_report(r);
		r.lt = 8'h00; r.rt = 8'h00;
		send_report(r);
		r.btn = 16'hFFFF;
		send_report(r);
		r.btn = 16'hFC00;
		send_report(r);
		r.btn = 16'h0000;
		send_report(r);
		r.hat = 4'hF;
		send_report(r);
		r.hat = 4'h8;
		send_report(r);
		r.hat = 4'h7;
		send_report(r);
		r.hat = 4'h0;
		send_report(r);
		send_report(r);
		r = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 8'hFF, 8'h01, 16'h0AAA, 4'h3};
		send_report(r);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_reports();
		random_reports(PHASE_ITEMS);

		set_config(2'd1, 0, AXIS_UNITY, 0, 65535);
		directed_reports();
		random_reports(PHASE_ITEMS);

		set_config(2'd2, 1000, 9000, -65536, 65535);
		random_reports(PHASE_ITEMS);

		set_config(2'd0, 2500, 7500, -100, 100);
		random_reports(20);

		set_config(2'd3, AXIS_UNITY, 0, -1000, 1000);
		random_reports(PHASE_ITEMS);

		set_config(2'd2, 16383, 16383, 65535, -65536);
		random_reports(PHASE_ITEMS);

		set_config(2'd1, 500, AXIS_UNITY, -32768, 32767);
		random_reports(PHASE_ITEMS);

		set_config(MODE_XIN, 0, AXIS_UNITY, 0, 65535);
		no_idle = 1'b1;
		random_reports(PHASE_ITEMS);
		no_idle = 1'b0;

		@(negedge clk);
		in_valid <= 1'b0;
		settle();

		$display("Sent %0d reports over eight register settings in all four layout modes,",
			reports_sent);
		$display("checked %0d event words with random gaps and stalls.", events_seen);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
